// File: rtl/core/smrc_pkg.sv
// Shared types for the row-count matrix sorter.
// Used by smrc_cell and sort_matrix_by_row_count; depends on nothing.
package smrc_pkg;

	localparam int unsigned ROW_W = 64;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned CNT_W = 7;

	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] cnt;
		logic [IDX_W-1:0] idx;
	} entry_t;

endpackage

// File: rtl/core/smrc_cell.sv
// One cell of the insertion chain that keeps rows ordered by cross count.
// Depends on smrc_pkg for entry_t.
module smrc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clr,
	input  logic            ins,
	input  smrc_pkg::entry_t new_ent,
	input  smrc_pkg::entry_t prev_ent,
	input  logic            prev_lt,
	output smrc_pkg::entry_t ent,
	output logic            lt
);
	import smrc_pkg::*;

	entry_t ent_q;

	// Strict compare keeps equal counts in arrival order.
	assign lt  = !ent_q.vld || (ent_q.cnt < new_ent.cnt);
	assign ent = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.vld <= 1'b0;
		end else if (clr) begin
			ent_q.vld <= 1'b0;
		end else if (ins && lt) begin
			ent_q <= prev_lt ? prev_ent : new_ent;
		end
	end

endmodule

// File: rtl/core/sort_matrix_by_row_count.sv
// Top level of the row-count matrix sorter: row memory, insertion chain, control.
// Depends on smrc_pkg and smrc_cell.
//
// Rows are loaded one word per cycle until matrix_size rows have arrived. The
// block then stalls its input, reads each row back from the row memory, counts
// its set bits below the size and inserts it into a chain of cells. Emission
// reads the rows one at a time, a read step then a write step, from the same
// row memory, permuting their columns by the sorted order. Equal counts keep
// their original row order. A size of 0 acts as 1 and a size above MAX_OBJECTS
// acts as MAX_OBJECTS.
module sort_matrix_by_row_count #(
	parameter int unsigned MAX_OBJECTS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [smrc_pkg::ROW_W-1:0] row_bits,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [smrc_pkg::ROW_W-1:0] out_row_bits,
	output logic [smrc_pkg::IDX_W-1:0] original_index,
	output logic [smrc_pkg::CNT_W-1:0] cross_count,
	output logic                  last_row,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [smrc_pkg::CNT_W-1:0] matrix_size
);
	import smrc_pkg::*;

	localparam int unsigned AW = $clog2(MAX_OBJECTS);
	localparam int unsigned NW = $clog2(MAX_OBJECTS + 1);
	localparam logic [CNT_W-1:0] MAX_SZ = CNT_W'(MAX_OBJECTS);

	typedef enum logic [1:0] {ST_LOAD, ST_SORT, ST_EMIT_RD, ST_EMIT_WR} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  size_q;
	logic [NW-1:0]     load_cnt_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     n_eff;
	logic [NW-1:0]     load_next;
	logic [NW-1:0]     sort_idx_q;
	logic [NW-1:0]     emit_idx_q;
	logic [ROW_W-1:0]  mem_q [MAX_OBJECTS];
	logic [ROW_W-1:0]  rd_data_s1;
	logic [AW-1:0]     rd_addr;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	entry_t            new_s2;
	logic              last_s2;
	logic              valid_s2;
	logic              issue;
	logic              in_acc;
	logic              out_load;
	logic              room;
	logic              chain_clr;
	logic [ROW_W-1:0]  col_mask;
	logic [ROW_W-1:0]  perm_bits;
	logic [CNT_W-1:0]  pop;
	entry_t            sel_s1;
	entry_t            cells [MAX_OBJECTS];
	logic              lts [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0] vld_vec;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_EMIT_WR) && (!out_valid || !out_stall);

	always_comb begin
		if (size_q == '0) begin
			n_eff = NW'(1);
		end else if (size_q > MAX_SZ) begin
			n_eff = NW'(MAX_OBJECTS);
		end else begin
			n_eff = NW'(size_q);
		end
	end

	assign room      = (load_cnt_q < NW'(MAX_OBJECTS));
	assign load_next = load_cnt_q + NW'(room);
	assign issue     = (state_q == ST_SORT) && (sort_idx_q < n_q);
	assign chain_clr = in_acc && (load_next >= n_eff);

	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			col_mask[j] = (j < int'(n_q));
		end
	end

	always_comb begin
		pop = '0;
		for (int j = 0; j < ROW_W; j++) begin
			pop = pop + CNT_W'(rd_data_s1[j] & col_mask[j]);
		end
	end

	always_comb begin
		perm_bits = '0;
		for (int j = 0; j < MAX_OBJECTS; j++) begin
			perm_bits[j] = (j < int'(n_q)) && rd_data_s1[cells[j].idx];
		end
	end

	assign rd_addr = (state_q == ST_SORT) ? sort_idx_q[AW-1:0]
		: cells[emit_idx_q[AW-1:0]].idx[AW-1:0];

	// Row memory: one write port for loading, one registered read port.
	always_ff @(posedge clk) begin
		if (in_acc && room) begin
			mem_q[load_cnt_q[AW-1:0]] <= row_bits;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		rd_idx_s1   <= IDX_W'(sort_idx_q[AW-1:0]);
		rd_last_s1  <= (sort_idx_q == n_q - NW'(1));
		new_s2.vld  <= 1'b1;
		new_s2.cnt  <= pop;
		new_s2.idx  <= rd_idx_s1;
		last_s2     <= rd_last_s1;
		sel_s1      <= cells[emit_idx_q[AW-1:0]];
	end

	for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
		smrc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (chain_clr),
			.ins      (valid_s2),
			.new_ent  (new_s2),
			.prev_ent ((i == 0) ? entry_t'('0) : cells[(i == 0) ? 0 : i - 1]),
			.prev_lt  ((i == 0) ? 1'b0 : lts[(i == 0) ? 0 : i - 1]),
			.ent      (cells[i]),
			.lt       (lts[i])
		);
		assign vld_vec[i] = cells[i].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			size_q     <= MAX_SZ;
			load_cnt_q <= '0;
			n_q        <= NW'(1);
			sort_idx_q <= '0;
			emit_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			valid_s2   <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= matrix_size;
			end
			rd_vld_s1 <= issue;
			valid_s2  <= rd_vld_s1;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (load_next >= n_eff) begin
							load_cnt_q <= '0;
							n_q        <= n_eff;
							sort_idx_q <= '0;
							state_q    <= ST_SORT;
						end else begin
							load_cnt_q <= load_next;
						end
					end
				end
				ST_SORT: begin
					if (issue) begin
						sort_idx_q <= sort_idx_q + NW'(1);
					end
					if (valid_s2 && last_s2) begin
						emit_idx_q <= '0;
						state_q    <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (out_load) begin
						out_row_bits   <= perm_bits;
						original_index <= sel_s1.idx;
						cross_count    <= sel_s1.cnt;
						last_row       <= (emit_idx_q == n_q - NW'(1));
						if (emit_idx_q == n_q - NW'(1)) begin
							state_q <= ST_LOAD;
						end else begin
							emit_idx_q <= emit_idx_q + NW'(1);
							state_q    <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// The filled cells always form an unbroken run from the head of the chain.
	a_chain_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_vec & (vld_vec + MAX_OBJECTS'(1))) == '0)
		else $error("insertion chain has a gap");

	// Every row of the matrix sits in the chain once emission starts.
	a_chain_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_WR)
		|-> ($countones(vld_vec) == int'(n_q)))
		else $error("chain does not hold the whole matrix");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_WR) |-> (emit_idx_q < n_q))
		else $error("emit index beyond matrix size");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q < NW'(MAX_OBJECTS))
		else $error("load count out of range");

	// A new word appears at the output only from the emit write step.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_EMIT_WR))
		else $error("output word without emit step");

endmodule
